>>> rtl/bba_pkg.sv
// shared types and codes for the buddy block allocator
package bba_pkg;

  localparam int LW_U = 27;
  localparam int LW_K = 5;

  typedef enum logic [1:0] {
    ST_ALLOC = 2'd0,
    ST_BAD   = 2'd1,
    ST_OOM   = 2'd2,
    ST_FREED = 2'd3
  } status_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic {
    LOP_PUSH   = 1'b0,
    LOP_REMOVE = 1'b1
  } lst_op_t;

  typedef struct packed {
    logic            vld;
    lst_op_t         op;
    logic [LW_K-1:0] k;
    logic [LW_U-1:0] u;
  } lst_cmd_t;

endpackage

>>> rtl/bba_ifs.sv
// request and result channel interfaces
interface bba_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [31:0] request_bytes;
  logic [15:0] free_offset;
  modport source(output valid, mode, request_bytes, free_offset, input ready);
  modport sink(input valid, mode, request_bytes, free_offset, output ready);
endinterface

interface bba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] user_offset;
  logic [3:0]  block_order;
  modport source(output valid, status, user_offset, block_order, input ready);
  modport sink(input valid, status, user_offset, block_order, output ready);
endinterface

>>> rtl/bba_list.sv
// free list unit: list heads and circular doubly linked next/prev memories
module bba_list import bba_pkg::*; #(
  parameter int UW      = 12,
  parameter int KW      = 4,
  parameter int NK      = 13,
  parameter int RST_TOP = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          init,
  input  logic [KW-1:0] init_top,
  input  lst_cmd_t      cmd,
  output logic          done,
  input  logic [KW-1:0] hd_k,
  output logic          hd_vld,
  output logic [UW-1:0] hd_u
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_RM   = 4'b0010,
    L_PT1  = 4'b0100,
    L_PT2  = 4'b1000
  } lst_state_t;

  lst_state_t st_r, st_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [UW-1:0] u_r, u_nxt, h_r, h_nxt, t_r, t_nxt;
  logic          done_r, done_nxt;

  logic          hvld_r [NK];
  logic [UW-1:0] hu_r   [NK];

  logic [UW-1:0] next_mem [2**UW];
  logic [UW-1:0] prev_mem [2**UW];
  logic [UW-1:0] nx_q, pv_q, rd_addr;
  logic          nx_we, pv_we;
  logic [UW-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

  logic          hd_we, hd_wvld;
  logic [KW-1:0] hd_wk;
  logic [UW-1:0] hd_wu;

  logic [KW-1:0] ck;
  logic [UW-1:0] cu;

  assign ck     = cmd.k[KW-1:0];
  assign cu     = cmd.u[UW-1:0];
  assign done   = done_r;
  assign hd_vld = hvld_r[hd_k];
  assign hd_u   = hu_r[hd_k];

  always_comb begin
    st_nxt   = st_r;
    k_nxt    = k_r;
    u_nxt    = u_r;
    h_nxt    = h_r;
    t_nxt    = t_r;
    done_nxt = 1'b0;
    rd_addr  = cu;
    nx_we    = 1'b0;
    pv_we    = 1'b0;
    nx_wa    = '0;
    nx_wd    = '0;
    pv_wa    = '0;
    pv_wd    = '0;
    hd_we    = 1'b0;
    hd_wvld  = 1'b0;
    hd_wk    = ck;
    hd_wu    = cu;
    case (st_r)
      L_IDLE: begin
        if (init) begin
          // unit 0 alone on the top list
          nx_we = 1'b1;
          pv_we = 1'b1;
        end else if (cmd.vld) begin
          k_nxt = ck;
          u_nxt = cu;
          if (cmd.op == LOP_REMOVE) begin
            st_nxt = L_RM;
          end else if (!hvld_r[ck]) begin
            nx_we    = 1'b1;
            nx_wa    = cu;
            nx_wd    = cu;
            pv_we    = 1'b1;
            pv_wa    = cu;
            pv_wd    = cu;
            hd_we    = 1'b1;
            hd_wvld  = 1'b1;
            done_nxt = 1'b1;
          end else begin
            rd_addr = hu_r[ck];
            h_nxt   = hu_r[ck];
            hd_we   = 1'b1;
            hd_wvld = 1'b1;
            st_nxt  = L_PT1;
          end
        end
      end
      L_RM: begin
        hd_wk = k_r;
        if (nx_q == u_r) begin
          hd_we   = 1'b1;
          hd_wvld = 1'b0;
        end else begin
          nx_we = 1'b1;
          nx_wa = pv_q;
          nx_wd = nx_q;
          pv_we = 1'b1;
          pv_wa = nx_q;
          pv_wd = pv_q;
          if (hu_r[k_r] == u_r) begin
            hd_we   = 1'b1;
            hd_wvld = 1'b1;
            hd_wu   = nx_q;
          end
        end
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      L_PT1: begin
        // pv_q is the tail of the list
        nx_we  = 1'b1;
        nx_wa  = u_r;
        nx_wd  = h_r;
        pv_we  = 1'b1;
        pv_wa  = u_r;
        pv_wd  = pv_q;
        t_nxt  = pv_q;
        st_nxt = L_PT2;
      end
      L_PT2: begin
        nx_we    = 1'b1;
        nx_wa    = t_r;
        nx_wd    = u_r;
        pv_we    = 1'b1;
        pv_wa    = h_r;
        pv_wd    = u_r;
        done_nxt = 1'b1;
        st_nxt   = L_IDLE;
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= L_IDLE;
      done_r <= 1'b0;
      for (int i = 0; i < NK; i++) begin
        hvld_r[i] <= (i == RST_TOP);
        hu_r[i]   <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      if (init) begin
        for (int i = 0; i < NK; i++) begin
          hvld_r[i] <= (KW'(i) == init_top);
          hu_r[i]   <= '0;
        end
      end else if (hd_we) begin
        hvld_r[hd_wk] <= hd_wvld;
        hu_r[hd_wk]   <= hd_wu;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    u_r <= u_nxt;
    h_r <= h_nxt;
    t_r <= t_nxt;
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    nx_q <= next_mem[rd_addr];
    pv_q <= prev_mem[rd_addr];
  end

endmodule

>>> rtl/buddy_block_allocator_unit.sv
// Buddy allocator over a heap of 2^HEAP_UNITS_LOG2 units of 2^MIN_BLOCK_LOG2 bytes. One item
// is handled at a time: in_ch.ready is high only when idle. An allocate checks the size, fits
// and searches an order, removes the found block and splits it down; a free checks the offset
// and merges with free buddies before the push. The fit and search loops step one order per
// cycle. A list remove passes through L_RM; a push onto an empty list is written straight
// from idle, and one onto a non-empty list steps through L_PT1 and L_PT2, on the next/prev
// memories. Reset and every write of cfg_data start a clearing pass over all 2^HEAP_UNITS_LOG2
// units. The pass marks every unit free and leaves the heap as one free top block, and
// in_ch.ready stays low during it. cfg_data is clamped to 1..HEAP_UNITS_LOG2+1.
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int HEAP_UNITS_LOG2 = 12,
  parameter int MIN_BLOCK_LOG2  = 4,
  parameter int HEADER_BYTES    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  bba_in_if.sink      in_ch,
  bba_out_if.source   out_ch
);

  localparam int UW   = HEAP_UNITS_LOG2;
  localparam int NK   = HEAP_UNITS_LOG2 + 1;
  localparam int KW   = $clog2(NK);
  localparam int OW   = $clog2(NK + 1);
  localparam int NW   = (MIN_BLOCK_LOG2 + HEAP_UNITS_LOG2 + 1 > 33) ?
                        MIN_BLOCK_LOG2 + HEAP_UNITS_LOG2 + 1 : 33;
  localparam int RST_OC = (13 > NK) ? NK : 13;

  typedef enum logic [14:0] {
    S_INIT  = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_ACHK  = 15'b000000000000100,
    S_FIT   = 15'b000000000001000,
    S_SRCH  = 15'b000000000010000,
    S_RMW   = 15'b000000000100000,
    S_SPLIT = 15'b000000001000000,
    S_PSHW  = 15'b000000010000000,
    S_FCHK  = 15'b000000100000000,
    S_FRD   = 15'b000001000000000,
    S_MRG   = 15'b000010000000000,
    S_MCHK  = 15'b000100000000000,
    S_MRW   = 15'b001000000000000,
    S_FPW   = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } bba_state_t;

  bba_state_t st_r, st_nxt;
  logic [OW-1:0] ocnt_r, ocnt_nxt;
  logic [OW-1:0] fit_r, fit_nxt, k_r, k_nxt, top;
  logic [UW-1:0] u_r, u_nxt;
  logic [UW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] need_r, need_nxt;
  logic          zero_r, zero_nxt;
  logic [15:0]   off_r, off_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic [15:0]   uoff_r, uoff_nxt;
  logic [3:0]    bord_r, bord_nxt;

  // unit meta memory: {free, order}
  logic [OW:0]   mt_mem [2**UW];
  logic [OW:0]   mt_q, mt_wd;
  logic [UW-1:0] mt_raddr, mt_wa;
  logic          mt_we;
  logic          mt_free;
  logic [OW-1:0] mt_ord;

  lst_cmd_t      cmd;
  logic          lst_init, lst_done, hd_vld;
  logic [UW-1:0] hd_u;

  logic [15:0]   rel;
  logic [63:0]   rel_u;
  logic [UW-1:0] bud, split_b, merged_u;
  logic [31:0]   cfg_ext, cfg_clamp;

  assign top      = ocnt_r - OW'(1);
  assign mt_free  = mt_q[OW];
  assign mt_ord   = mt_q[OW-1:0];
  assign rel      = off_r - 16'(HEADER_BYTES);
  assign rel_u    = 64'(rel) >> MIN_BLOCK_LOG2;
  assign bud      = u_r ^ (UW'(1) << k_r);
  assign split_b  = u_r ^ (UW'(1) << (k_r - OW'(1)));
  assign merged_u = u_r & ~(UW'(1) << k_r);
  assign cfg_ext  = 32'(cfg_data);
  assign cfg_clamp = (cfg_ext < 32'd1) ? 32'd1 :
                     (cfg_ext > 32'(NK)) ? 32'(NK) : cfg_ext;

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = (st_r == S_OUT);
  assign out_ch.status      = stat_r;
  assign out_ch.user_offset = uoff_r;
  assign out_ch.block_order = bord_r;

  function automatic logic [15:0] user_off(input logic [UW-1:0] u);
    logic [63:0] t;
    t = (64'(u) << MIN_BLOCK_LOG2) + 64'(HEADER_BYTES);
    return t[15:0];
  endfunction

  always_comb begin
    st_nxt   = st_r;
    ocnt_nxt = ocnt_r;
    fit_nxt  = fit_r;
    k_nxt    = k_r;
    u_nxt    = u_r;
    clr_nxt  = clr_r;
    need_nxt = need_r;
    zero_nxt = zero_r;
    off_nxt  = off_r;
    stat_nxt = stat_r;
    uoff_nxt = uoff_r;
    bord_nxt = bord_r;
    mt_raddr = u_r;
    mt_we    = 1'b0;
    mt_wa    = u_r;
    mt_wd    = '0;
    lst_init = 1'b0;
    cmd      = '0;
    case (st_r)
      S_INIT: begin
        // clearing pass: every unit free, unit 0 heads the top block
        lst_init = 1'b1;
        mt_we    = 1'b1;
        mt_wa    = clr_r;
        mt_wd    = (clr_r == '0) ? {1'b1, top} : {1'b1, OW'(0)};
        clr_nxt  = clr_r + UW'(1);
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          need_nxt = NW'(in_ch.request_bytes) + NW'(HEADER_BYTES);
          zero_nxt = (in_ch.request_bytes == 32'd0);
          off_nxt  = in_ch.free_offset;
          st_nxt   = (in_ch.mode == MODE_FREE) ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        fit_nxt = '0;
        if (zero_r || need_r > (NW'(1) << (MIN_BLOCK_LOG2 + 32'(top)))) begin
          stat_nxt = ST_BAD;
          uoff_nxt = '0;
          bord_nxt = '0;
          st_nxt   = S_OUT;
        end else begin
          st_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if (fit_r < top && (NW'(1) << (MIN_BLOCK_LOG2 + 32'(fit_r))) < need_r) begin
          fit_nxt = fit_r + OW'(1);
        end else begin
          k_nxt  = fit_r;
          st_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (k_r > top) begin
          stat_nxt = ST_OOM;
          uoff_nxt = '0;
          bord_nxt = '0;
          st_nxt   = S_OUT;
        end else if (hd_vld) begin
          u_nxt   = hd_u;
          cmd.vld = 1'b1;
          cmd.op  = LOP_REMOVE;
          cmd.k   = LW_K'(k_r);
          cmd.u   = LW_U'(hd_u);
          st_nxt  = S_RMW;
        end else begin
          k_nxt = k_r + OW'(1);
        end
      end
      S_RMW: begin
        if (lst_done) st_nxt = S_SPLIT;
      end
      S_SPLIT: begin
        if (k_r > fit_r) begin
          // upper buddy goes back on the list one order down
          k_nxt   = k_r - OW'(1);
          mt_we   = 1'b1;
          mt_wa   = split_b;
          mt_wd   = {1'b1, k_r - OW'(1)};
          cmd.vld = 1'b1;
          cmd.op  = LOP_PUSH;
          cmd.k   = LW_K'(k_r - OW'(1));
          cmd.u   = LW_U'(split_b);
          st_nxt  = S_PSHW;
        end else begin
          mt_we    = 1'b1;
          mt_wa    = u_r;
          mt_wd    = {1'b0, fit_r};
          stat_nxt = ST_ALLOC;
          uoff_nxt = user_off(u_r);
          bord_nxt = 4'(fit_r);
          st_nxt   = S_OUT;
        end
      end
      S_PSHW: begin
        if (lst_done) st_nxt = S_SPLIT;
      end
      S_FCHK: begin
        mt_raddr = UW'(rel_u);
        u_nxt    = UW'(rel_u);
        if (off_r < 16'(HEADER_BYTES) || (64'(rel) & ((64'd1 << MIN_BLOCK_LOG2) - 64'd1)) != 0
            || rel_u >= (64'd1 << top)) begin
          stat_nxt = ST_BAD;
          uoff_nxt = '0;
          bord_nxt = '0;
          st_nxt   = S_OUT;
        end else begin
          st_nxt = S_FRD;
        end
      end
      S_FRD: begin
        if (mt_free || mt_ord > top ||
            (64'(u_r) & ((64'd1 << mt_ord) - 64'd1)) != 0) begin
          stat_nxt = ST_BAD;
          uoff_nxt = '0;
          bord_nxt = '0;
          st_nxt   = S_OUT;
        end else begin
          mt_we  = 1'b1;
          mt_wa  = u_r;
          mt_wd  = {1'b1, mt_ord};
          k_nxt  = mt_ord;
          st_nxt = S_MRG;
        end
      end
      S_MRG: begin
        if (k_r < top) begin
          mt_raddr = bud;
          st_nxt   = S_MCHK;
        end else begin
          cmd.vld = 1'b1;
          cmd.op  = LOP_PUSH;
          cmd.k   = LW_K'(k_r);
          cmd.u   = LW_U'(u_r);
          st_nxt  = S_FPW;
        end
      end
      S_MCHK: begin
        cmd.vld = 1'b1;
        cmd.k   = LW_K'(k_r);
        if (!mt_free || mt_ord != k_r) begin
          cmd.op = LOP_PUSH;
          cmd.u  = LW_U'(u_r);
          st_nxt = S_FPW;
        end else begin
          cmd.op = LOP_REMOVE;
          cmd.u  = LW_U'(bud);
          st_nxt = S_MRW;
        end
      end
      S_MRW: begin
        if (lst_done) begin
          u_nxt  = merged_u;
          k_nxt  = k_r + OW'(1);
          mt_we  = 1'b1;
          mt_wa  = merged_u;
          mt_wd  = {1'b1, k_r + OW'(1)};
          st_nxt = S_MRG;
        end
      end
      S_FPW: begin
        if (lst_done) begin
          stat_nxt = ST_FREED;
          uoff_nxt = user_off(u_r);
          bord_nxt = 4'(k_r);
          st_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) st_nxt = S_IDLE;
      end
      default: begin
        st_nxt  = S_INIT;
        clr_nxt = '0;
      end
    endcase
    if (cfg_we) begin
      ocnt_nxt = OW'(cfg_clamp);
      clr_nxt  = '0;
      st_nxt   = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_INIT;
      ocnt_r <= OW'(RST_OC);
      clr_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      ocnt_r <= ocnt_nxt;
      clr_r  <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fit_r  <= fit_nxt;
    k_r    <= k_nxt;
    u_r    <= u_nxt;
    need_r <= need_nxt;
    zero_r <= zero_nxt;
    off_r  <= off_nxt;
    stat_r <= stat_nxt;
    uoff_r <= uoff_nxt;
    bord_r <= bord_nxt;
  end

  always_ff @(posedge clk) begin
    if (mt_we) mt_mem[mt_wa] <= mt_wd;
    mt_q <= mt_mem[mt_raddr];
  end

  bba_list #(
    .UW      (UW),
    .KW      (KW),
    .NK      (NK),
    .RST_TOP (RST_OC - 1)
  ) u_list (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (lst_init),
    .init_top (KW'(top)),
    .cmd      (cmd),
    .done     (lst_done),
    .hd_k     (KW'(k_r)),
    .hd_vld   (hd_vld),
    .hd_u     (hd_u)
  );

endmodule

>>> rtl/bba_chk.sv
// port-level checks for the buddy block allocator, bound to the top level
module bba_chk import bba_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_user_offset,
  input logic [3:0]  out_block_order
);

  // one word in flight: never ready while a result waits
  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BAD || out_status == ST_OOM)
      |-> out_user_offset == 16'd0 && out_block_order == 4'd0)
    else $error("error result carries nonzero fields");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_user_offset) && $stable(out_block_order))
    else $error("stalled result changed");

endmodule

bind buddy_block_allocator_unit bba_chk u_bba_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_user_offset (out_ch.user_offset),
  .out_block_order (out_ch.block_order)
);
